// ===== rtl/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-32 forcing patch package
// Shared types, constants and helpers for the CRC-32 forcing patch block.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

  localparam int unsigned CRC_W = 32;
  localparam int unsigned LEN_W = 29;
  localparam int unsigned CNT_W = $clog2(CRC_W);

  // Low 32 bits of the generator 0x104C11DB7; the x^32 term is implicit.
  localparam logic [CRC_W-1:0] GEN_LOW   = 32'h04C1_1DB7;
  // Inverse of x modulo the generator.
  localparam logic [CRC_W-1:0] X_INVERSE = 32'h8260_8EDB;

  // Operand pairs for the shared bit-serial multiplier.
  typedef enum logic [1:0] {
    SEL_ZB,  // running power times base
    SEL_BB,  // base squared
    SEL_ZD   // final power times the CRC difference
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;      // capture a new input word
    logic     mul_load;  // load multiplier operands, clear accumulator
    mul_sel_e mul_sel;
    logic     mul_step;  // one shift-and-add step
    logic     wb_z;      // product into the running power
    logic     wb_base;   // product into the base, shift the exponent
    logic     wb_out;    // bit-reversed product into the output register
  } cfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic e_lsb;  // current exponent bit
  } cfp_sts_t;

  function automatic logic [CRC_W-1:0] bit_rev(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < int'(CRC_W); i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cfp_dp.sv =====
// ----------------------------------------------------------------------------
// CRC-32 forcing patch datapath
// Operand registers, exponent shifter and one bit-serial GF(2) multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cfp_pkg::cfp_cmd_t             cmd_i,
  output cfp_pkg::cfp_sts_t                  sts_o,
  input  wire logic [cfp_pkg::LEN_W-1:0]     buffer_length_i,
  input  wire logic [cfp_pkg::LEN_W-1:0]     patch_offset_i,
  input  wire logic [cfp_pkg::CRC_W-1:0]     current_crc_i,
  input  wire logic [cfp_pkg::CRC_W-1:0]     target_crc_i,
  output logic      [cfp_pkg::CRC_W-1:0]     patch_mask_o
);

  localparam int unsigned W = cfp_pkg::CRC_W;

  logic [cfp_pkg::LEN_W-1:0] diff;
  logic [W-1:0] e_q, z_q, base_q, d_q, a_q, b_q, acc_q, mask_q;
  logic [W-1:0] a_shift;

  // Byte distance modulo 2^29, times eight: the bit distance modulo 2^32.
  assign diff    = buffer_length_i - patch_offset_i;
  assign a_shift = a_q[W-1] ? ({a_q[W-2:0], 1'b0} ^ cfp_pkg::GEN_LOW)
                            : {a_q[W-2:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      e_q    <= {diff, 3'b000};
      z_q    <= W'(1);
      base_q <= cfp_pkg::X_INVERSE;
      d_q    <= current_crc_i ^ target_crc_i;
    end
    if (cmd_i.wb_z) begin
      z_q <= acc_q;
    end
    if (cmd_i.wb_base) begin
      base_q <= acc_q;
      e_q    <= {1'b0, e_q[W-1:1]};
    end
    if (cmd_i.mul_load) begin
      acc_q <= '0;
      case (cmd_i.mul_sel)
        cfp_pkg::SEL_ZB: begin
          a_q <= z_q;
          b_q <= base_q;
        end
        cfp_pkg::SEL_BB: begin
          a_q <= base_q;
          b_q <= base_q;
        end
        default: begin
          a_q <= z_q;
          b_q <= d_q;
        end
      endcase
    end else if (cmd_i.mul_step) begin
      if (b_q[0]) begin
        acc_q <= acc_q ^ a_q;
      end
      a_q <= a_shift;
      b_q <= {1'b0, b_q[W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cmd_i.wb_out) begin
      mask_q <= cfp_pkg::bit_rev(acc_q);
    end
  end

  assign sts_o.e_lsb = e_q[0];
  assign patch_mask_o = mask_q;

endmodule

`default_nettype wire

// ===== rtl/cfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// CRC-32 forcing patch controller
// Sequences square-and-multiply over the exponent bits and the final product.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output cfp_pkg::cfp_cmd_t      cmd_o,
  input  wire cfp_pkg::cfp_sts_t sts_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PICK = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  localparam logic [1:0] OP_MULZ  = 2'd0;
  localparam logic [1:0] OP_SQR   = 2'd1;
  localparam logic [1:0] OP_FINAL = 2'd2;

  localparam int unsigned CW = cfp_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(cfp_pkg::CRC_W - 1);

  logic [1:0]    state_q, state_d;
  logic [1:0]    op_q, op_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ecnt_q, ecnt_d;
  logic          mulz_done_q, mulz_done_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.mul_sel = cfp_pkg::SEL_ZB;
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    ecnt_d      = ecnt_q;
    mulz_done_d = mulz_done_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          ecnt_d      = '0;
          mulz_done_d = 1'b0;
          state_d     = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.mul_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_RUN;
        if (!mulz_done_q && sts_i.e_lsb) begin
          cmd_o.mul_sel = cfp_pkg::SEL_ZB;
          op_d          = OP_MULZ;
        end else begin
          cmd_o.mul_sel = cfp_pkg::SEL_BB;
          op_d          = OP_SQR;
        end
      end
      S_RUN: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        case (op_q)
          OP_MULZ: begin
            cmd_o.wb_z  = 1'b1;
            mulz_done_d = 1'b1;
            state_d     = S_PICK;
          end
          OP_SQR: begin
            cmd_o.wb_base = 1'b1;
            if (ecnt_q == CNT_LAST) begin
              cmd_o.mul_load = 1'b1;
              cmd_o.mul_sel  = cfp_pkg::SEL_ZD;
              op_d           = OP_FINAL;
              cnt_d          = '0;
              state_d        = S_RUN;
            end else begin
              ecnt_d      = ecnt_q + 1'b1;
              mulz_done_d = 1'b0;
              state_d     = S_PICK;
            end
          end
          default: begin
            // Hold the product until the output register is free.
            if (!out_valid_q || !out_stall_i) begin
              cmd_o.wb_out = 1'b1;
              out_valid_d  = 1'b1;
              state_d      = S_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_MULZ;
      cnt_q       <= '0;
      ecnt_q      <= '0;
      mulz_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      ecnt_q      <= ecnt_d;
      mulz_done_q <= mulz_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/crc32_forcing_patch.sv =====
// ----------------------------------------------------------------------------
// CRC-32 forcing patch
// Computes the 32-bit XOR mask that forces a raw CRC-32 to a wanted value.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_stall_o   buffer_length, patch_offset,
//                                                 current_crc, target_crc
//   output   out        out_valid_o / out_stall_i patch_mask
//
// One word is worked at a time by the single bit-serial multiplier, and the
// input stays stalled until it is done: each of the 32 exponent bits costs
// one squaring plus, for a one bit, one multiply, and the final product
// follows. The number of multiplies is the number of set bits of the bit
// distance (at most 29).
// Reset is asynchronous and active low and returns the controller to idle.
// A finished mask sits in the output register while a new word is accepted;
// if that mask is still stalled when the next one is done, the controller
// holds in its write-back step until the register frees up.
//
// The mask is the bit-reversed product of current_crc ^ target_crc with
// x^(-d) modulo 0x104C11DB7, d being eight times the byte distance from the
// patch offset to the end of the data, modulo 2^32. The inverse power is
// formed as (x^-1)^d by square and multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_forcing_patch (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [cfp_pkg::LEN_W-1:0] buffer_length_i,
  input  wire logic [cfp_pkg::LEN_W-1:0] patch_offset_i,
  input  wire logic [cfp_pkg::CRC_W-1:0] current_crc_i,
  input  wire logic [cfp_pkg::CRC_W-1:0] target_crc_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic      [cfp_pkg::CRC_W-1:0] patch_mask_o
);

  cfp_pkg::cfp_cmd_t cmd;
  cfp_pkg::cfp_sts_t sts;

  // The controller owns the handshakes and the step counters.
  cfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the operands, the multiplier and the mask register.
  cfp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .buffer_length_i (buffer_length_i),
    .patch_offset_i  (patch_offset_i),
    .current_crc_i   (current_crc_i),
    .target_crc_i    (target_crc_i),
    .patch_mask_o    (patch_mask_o)
  );

endmodule

`default_nettype wire

// ===== rtl/cfp_checker.sv =====
// ----------------------------------------------------------------------------
// CRC-32 forcing patch checker
// Port-level checks on handshake timing of the forcing patch block.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [cfp_pkg::CRC_W-1:0] patch_mask_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // Once a word is taken, the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after an accepted word");

  // A stalled mask stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(patch_mask_o))
    else $error("stalled mask changed or dropped");

  // A new mask only appears at the end of busy work.
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("mask appeared without work in progress");

  // No mask can be produced the cycle right after a word is accepted.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("mask appeared too early");

endmodule

bind crc32_forcing_patch cfp_checker u_cfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .patch_mask_o (patch_mask_o)
);

`default_nettype wire
